/* rtl/ipcd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ipcd_pkg
// Shared types and constants of the inverse Park/Clarke duty core: word
// formats of both channels, inter-stage words and fixed-point constants.
// ----------------------------------------------------------------------------
package ipcd_pkg;

    // Default configuration
    localparam int SINE_TABLE_BITS_DEF = 10;
    localparam int ANGLE_BITS_DEF      = 16;

    // Fixed-point constants
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam logic signed [17:0] SQRT3_HALF_Q16 = 18'sd56756;
    localparam logic [15:0] INV_HALF_BUS_RESET = 16'd2731;
    localparam logic [15:0] DUTY_FULL = 16'd32768;

    // Pipeline depth: two sine/cosine stages, three transform stages,
    // four duty stages
    localparam int NUM_STAGES = 9;

    // Internal widths
    localparam int PROD_W  = 33;  // 16 x 17 signed product
    localparam int PHASE_W = 37;  // phase voltage, Q23
    localparam int DUTY_W  = 32;  // scaled duty before shift and clamp

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } quad_t;

    typedef struct packed {
        logic signed [15:0] volt_d;
        logic signed [15:0] volt_q;
        logic [15:0]        angle;
    } in_word_t;

    typedef struct packed {
        logic [15:0] duty_u;
        logic [15:0] duty_v;
        logic [15:0] duty_w;
    } out_word_t;

    // Park products: d*cos, q*sin, d*sin, q*cos
    typedef struct packed {
        logic signed [PROD_W-1:0] dc;
        logic signed [PROD_W-1:0] qs;
        logic signed [PROD_W-1:0] ds;
        logic signed [PROD_W-1:0] qc;
    } prod_t;

    typedef struct packed {
        logic signed [PHASE_W-1:0] pu;
        logic signed [PHASE_W-1:0] pv;
        logic signed [PHASE_W-1:0] pw;
    } phase_t;

    // Per-stage advance strobes, grouped by the module that owns the stages
    typedef struct packed {
        logic [1:0] sincos;
        logic [2:0] transform;
        logic [3:0] duty;
    } stage_adv_t;

    // Saturate a shifted duty to 0..full on
    function automatic logic [15:0] clamp_duty(logic signed [DUTY_W:0] v);
        logic [15:0] r;
        if (v < 0) begin
            r = 16'd0;
        end else if (v > $signed({17'd0, DUTY_FULL})) begin
            r = DUTY_FULL;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* rtl/ipcd_sincos.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ipcd_sincos
// Quarter-wave sine lookup with quadrant folding, followed by the four
// products of the inverse Park transform.
// ----------------------------------------------------------------------------
module ipcd_sincos #(
    parameter int SINE_TABLE_BITS = ipcd_pkg::SINE_TABLE_BITS_DEF,
    parameter int ANGLE_BITS      = ipcd_pkg::ANGLE_BITS_DEF
) (
    input  logic                clk,
    input  ipcd_pkg::stage_adv_t adv,
    input  ipcd_pkg::in_word_t  in_word,
    output ipcd_pkg::prod_t     prod
);

    localparam int IDX_W   = SINE_TABLE_BITS + 2;
    localparam int QUARTER = 1 << SINE_TABLE_BITS;

    typedef logic [15:0] lut_t [0:QUARTER];

    // Build the quarter-wave table: Taylor series to x^9 in Q30, then Q15
    function automatic lut_t build_lut();
        lut_t              t;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   term;
        longint            sum;
        for (int k = 0; k <= QUARTER; k++) begin
            x    = (longint'(k) * ipcd_pkg::HALF_PI_Q30) >> SINE_TABLE_BITS;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            term = ((term * x2) >> 30) / 6;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 30) / 20;
            sum  = sum + longint'(term);
            term = ((term * x2) >> 30) / 42;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 30) / 72;
            sum  = sum + longint'(term);
            if (sum < 0) begin
                sum = 0;
            end
            t[k] = 16'((sum + 64'sd16384) >>> 15);
        end
        return t;
    endfunction

    localparam lut_t SINE_LUT = build_lut();

    logic [ANGLE_BITS-1:0]        phase;
    logic [IDX_W-1:0]             idx;
    logic [SINE_TABLE_BITS:0]     addr_a;
    logic [SINE_TABLE_BITS:0]     addr_b;

    logic [15:0]                  a_reg, a_next;
    logic [15:0]                  b_reg, b_next;
    ipcd_pkg::quad_t              quad_reg, quad_next;
    logic signed [15:0]           d_reg;
    logic signed [15:0]           q_reg;

    logic signed [16:0]           s_val;
    logic signed [16:0]           c_val;
    ipcd_pkg::prod_t              prod_reg, prod_next;

    // Fit the angle word to the angle width
    generate
        if (ANGLE_BITS > 16) begin : g_phase_wide
            assign phase = {{(ANGLE_BITS - 16){1'b0}}, in_word.angle};
        end else begin : g_phase_narrow
            assign phase = in_word.angle[ANGLE_BITS-1:0];
        end
    endgenerate

    // Take the top table-index bits, padding a short angle on the right
    generate
        if (ANGLE_BITS > IDX_W) begin : g_idx_cut
            assign idx = phase[ANGLE_BITS-1 -: IDX_W];
        end else if (ANGLE_BITS == IDX_W) begin : g_idx_same
            assign idx = phase;
        end else begin : g_idx_pad
            assign idx = {phase, {(IDX_W - ANGLE_BITS){1'b0}}};
        end
    endgenerate

    // Look up sine at k and at the mirrored point
    always_comb
    begin
        addr_a    = {1'b0, idx[SINE_TABLE_BITS-1:0]};
        addr_b    = (SINE_TABLE_BITS + 1)'(QUARTER) - addr_a;
        a_next    = SINE_LUT[addr_a];
        b_next    = SINE_LUT[addr_b];
        quad_next = ipcd_pkg::quad_t'(idx[IDX_W-1 -: 2]);
    end

    // Stage 0: hold table words, quadrant and voltages
    always_ff @(posedge clk)
    begin
        if (adv.sincos[0])
        begin
            a_reg    <= a_next;
            b_reg    <= b_next;
            quad_reg <= quad_next;
            d_reg    <= in_word.volt_d;
            q_reg    <= in_word.volt_q;
        end
    end

    // Fold the quadrant into signed sine and cosine
    always_comb
    begin
        unique case (quad_reg)
            ipcd_pkg::QUAD_0:
            begin
                s_val = $signed({1'b0, a_reg});
                c_val = $signed({1'b0, b_reg});
            end
            ipcd_pkg::QUAD_1:
            begin
                s_val = $signed({1'b0, b_reg});
                c_val = -$signed({1'b0, a_reg});
            end
            ipcd_pkg::QUAD_2:
            begin
                s_val = -$signed({1'b0, a_reg});
                c_val = -$signed({1'b0, b_reg});
            end
            default:
            begin
                s_val = -$signed({1'b0, b_reg});
                c_val = $signed({1'b0, a_reg});
            end
        endcase
        prod_next.dc = ipcd_pkg::PROD_W'(d_reg) * ipcd_pkg::PROD_W'(c_val);
        prod_next.qs = ipcd_pkg::PROD_W'(q_reg) * ipcd_pkg::PROD_W'(s_val);
        prod_next.ds = ipcd_pkg::PROD_W'(d_reg) * ipcd_pkg::PROD_W'(s_val);
        prod_next.qc = ipcd_pkg::PROD_W'(q_reg) * ipcd_pkg::PROD_W'(c_val);
    end

    // Stage 1: hold the four products
    always_ff @(posedge clk)
    begin
        if (adv.sincos[1])
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule
`default_nettype wire

/* rtl/ipcd_transform.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ipcd_transform
// Inverse Park sums into alpha/beta, then the inverse Clarke transform into
// three phase voltages in Q23.
// ----------------------------------------------------------------------------
module ipcd_transform (
    input  logic                 clk,
    input  ipcd_pkg::stage_adv_t adv,
    input  ipcd_pkg::prod_t      prod,
    output ipcd_pkg::phase_t     phase
);

    localparam int AB_W  = ipcd_pkg::PROD_W + 1;
    localparam int BK_W  = AB_W + 18;
    localparam int SUM_W = BK_W + 1;

    logic signed [AB_W-1:0]  alpha_reg, alpha_next;
    logic signed [AB_W-1:0]  beta_reg, beta_next;
    logic signed [AB_W-1:0]  alpha2_reg;
    logic signed [BK_W-1:0]  bk_reg, bk_next;
    logic signed [SUM_W-1:0] neg_a;
    logic signed [SUM_W-1:0] sum_v;
    logic signed [SUM_W-1:0] sum_w;
    ipcd_pkg::phase_t        phase_reg, phase_next;

    // Form alpha and beta
    always_comb
    begin
        alpha_next = AB_W'(prod.dc) - AB_W'(prod.qs);
        beta_next  = AB_W'(prod.ds) + AB_W'(prod.qc);
    end

    // Stage 2: hold alpha and beta
    always_ff @(posedge clk)
    begin
        if (adv.transform[0])
        begin
            alpha_reg <= alpha_next;
            beta_reg  <= beta_next;
        end
    end

    // Scale beta by sqrt(3)/2
    assign bk_next = BK_W'(beta_reg) * BK_W'(ipcd_pkg::SQRT3_HALF_Q16);

    // Stage 3: hold alpha and scaled beta
    always_ff @(posedge clk)
    begin
        if (adv.transform[1])
        begin
            alpha2_reg <= alpha_reg;
            bk_reg     <= bk_next;
        end
    end

    // Combine into V and W, round half up by 16 bits
    always_comb
    begin
        neg_a         = -(SUM_W'(alpha2_reg) <<< 15);
        sum_v         = neg_a + SUM_W'(bk_reg);
        sum_w         = neg_a - SUM_W'(bk_reg);
        phase_next.pu = ipcd_pkg::PHASE_W'(alpha2_reg);
        phase_next.pv = ipcd_pkg::PHASE_W'((sum_v + SUM_W'(32768)) >>> 16);
        phase_next.pw = ipcd_pkg::PHASE_W'((sum_w + SUM_W'(32768)) >>> 16);
    end

    // Stage 4: hold phase voltages
    always_ff @(posedge clk)
    begin
        if (adv.transform[2])
        begin
            phase_reg <= phase_next;
        end
    end

    assign phase = phase_reg;

endmodule
`default_nettype wire

/* rtl/ipcd_duty.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ipcd_duty
// Scales phase voltages by the bus reciprocal, lifts all three by the most
// negative one when it is below zero and clamps each duty to 0..full on.
// ----------------------------------------------------------------------------
module ipcd_duty (
    input  logic                 clk,
    input  ipcd_pkg::stage_adv_t adv,
    input  logic [15:0]          inv_half_bus,
    input  ipcd_pkg::phase_t     phase,
    output ipcd_pkg::out_word_t  out_word
);

    localparam int MUL_W = ipcd_pkg::PHASE_W + 17;
    localparam int DW    = ipcd_pkg::DUTY_W;

    logic signed [16:0]    inv_s;
    logic signed [MUL_W-1:0] mu_reg, mv_reg, mw_reg;
    logic signed [DW-1:0]  du_reg, dv_reg, dw_reg;
    logic signed [DW-1:0]  du2_reg, dv2_reg, dw2_reg;
    logic signed [DW-1:0]  shift_reg, shift_next;
    logic signed [DW-1:0]  min_uv;
    logic signed [DW-1:0]  min_all;
    ipcd_pkg::out_word_t   out_reg, out_next;

    assign inv_s = $signed({1'b0, inv_half_bus});

    // Stage 5: multiply each phase by the bus reciprocal
    always_ff @(posedge clk)
    begin
        if (adv.duty[0])
        begin
            mu_reg <= MUL_W'(phase.pu) * MUL_W'(inv_s);
            mv_reg <= MUL_W'(phase.pv) * MUL_W'(inv_s);
            mw_reg <= MUL_W'(phase.pw) * MUL_W'(inv_s);
        end
    end

    // Stage 6: round half up by 22 bits to Q15
    always_ff @(posedge clk)
    begin
        if (adv.duty[1])
        begin
            du_reg <= DW'((mu_reg + MUL_W'(2097152)) >>> 22);
            dv_reg <= DW'((mv_reg + MUL_W'(2097152)) >>> 22);
            dw_reg <= DW'((mw_reg + MUL_W'(2097152)) >>> 22);
        end
    end

    // Find the smallest duty; keep it only when negative
    always_comb
    begin
        min_uv     = (dv_reg < du_reg) ? dv_reg : du_reg;
        min_all    = (dw_reg < min_uv) ? dw_reg : min_uv;
        shift_next = (min_all < 0) ? min_all : '0;
    end

    // Stage 7: hold duties and shift amount
    always_ff @(posedge clk)
    begin
        if (adv.duty[2])
        begin
            du2_reg   <= du_reg;
            dv2_reg   <= dv_reg;
            dw2_reg   <= dw_reg;
            shift_reg <= shift_next;
        end
    end

    // Lift and clamp
    always_comb
    begin
        out_next.duty_u = ipcd_pkg::clamp_duty((DW + 1)'(du2_reg) - (DW + 1)'(shift_reg));
        out_next.duty_v = ipcd_pkg::clamp_duty((DW + 1)'(dv2_reg) - (DW + 1)'(shift_reg));
        out_next.duty_w = ipcd_pkg::clamp_duty((DW + 1)'(dw2_reg) - (DW + 1)'(shift_reg));
    end

    // Stage 8: output word
    always_ff @(posedge clk)
    begin
        if (adv.duty[3])
        begin
            out_reg <= out_next;
        end
    end

    assign out_word = out_reg;

endmodule
`default_nettype wire

/* rtl/inverse_park_clarke_duty_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// inverse_park_clarke_duty_core
// Turns d/q voltages and an electrical angle into three clamped PWM duties.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (volt_d, volt_q, angle) arrive on in_valid/in_stall/in_word;
//   a word is taken at a clock edge with in_valid high and in_stall low.
//   Duty words leave on out_valid/out_stall/out_word, taken the same way.
//   The bus reciprocal is written through cfg_wen/cfg_wdata; the user must
//   write it only while the core is idle, which the core does not enforce;
//   it resets to the 12 V value. Throughput is one word per cycle while the
//   receiver does not stall: every stage of the nine-stage pipeline holds
//   its own word. When the receiver stalls, the output word holds and
//   stages behind it keep filling empty slots; in_stall rises only once
//   the pipeline is full up to the first stage. Reset empties the pipeline
//   and restores the bus reciprocal.
// ----------------------------------------------------------------------------
module inverse_park_clarke_duty_core #(
    parameter int SINE_TABLE_BITS = ipcd_pkg::SINE_TABLE_BITS_DEF,
    parameter int ANGLE_BITS      = ipcd_pkg::ANGLE_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wen,
    input  logic [15:0]         cfg_wdata,
    input  logic                in_valid,
    output logic                in_stall,
    input  ipcd_pkg::in_word_t  in_word,
    output logic                out_valid,
    input  logic                out_stall,
    output ipcd_pkg::out_word_t out_word
);

    localparam int NS = ipcd_pkg::NUM_STAGES;

    logic [15:0]          inv_reg;
    logic [NS-1:0]        valid_reg, valid_next;
    logic [NS-1:0]        adv_v;
    ipcd_pkg::stage_adv_t adv;
    ipcd_pkg::prod_t      prod;
    ipcd_pkg::phase_t     phase;

    // Hold the bus reciprocal
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_reg <= ipcd_pkg::INV_HALF_BUS_RESET;
        end
        else if (cfg_wen)
        begin
            inv_reg <= cfg_wdata;
        end
    end

    // Advance a stage when it is empty or the next one advances
    always_comb
    begin
        adv_v[NS-1] = !valid_reg[NS-1] || !out_stall;
        for (int i = NS - 2; i >= 0; i--)
        begin
            adv_v[i] = !valid_reg[i] || adv_v[i+1];
        end
        valid_next[0] = adv_v[0] ? in_valid : valid_reg[0];
        for (int i = 1; i < NS; i++)
        begin
            valid_next[i] = adv_v[i] ? valid_reg[i-1] : valid_reg[i];
        end
        adv.sincos    = adv_v[1:0];
        adv.transform = adv_v[4:2];
        adv.duty      = adv_v[8:5];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_stall  = !adv_v[0];
    assign out_valid = valid_reg[NS-1];

    ipcd_sincos #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS),
        .ANGLE_BITS      (ANGLE_BITS)
    ) u_sincos (
        .clk     (clk),
        .adv     (adv),
        .in_word (in_word),
        .prod    (prod)
    );

    ipcd_transform u_transform (
        .clk   (clk),
        .adv   (adv),
        .prod  (prod),
        .phase (phase)
    );

    ipcd_duty u_duty (
        .clk          (clk),
        .adv          (adv),
        .inv_half_bus (inv_reg),
        .phase        (phase),
        .out_word     (out_word)
    );

`ifndef SYNTHESIS
    // Input side stalls only behind a stalled, full output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stall without a stalled output word");

    // An accepted word lands in the first stage
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> valid_reg[0])
        else $error("accepted word lost at first stage");

    // Duties never exceed full on
    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_word.duty_u <= ipcd_pkg::DUTY_FULL
                    && out_word.duty_v <= ipcd_pkg::DUTY_FULL
                    && out_word.duty_w <= ipcd_pkg::DUTY_FULL))
        else $error("duty above full scale");
`endif

endmodule
`default_nettype wire
